// File: src/hsvr_pkg.sv
package hsvr_pkg;

  // Component format: all ones stands for 1.0
  localparam int COMP_BITS = 8;
  localparam int COMP_MAX = (1 << COMP_BITS) - 1;
  localparam int PROD_BITS = 2 * COMP_BITS;

  // Hue in whole degrees, split into sixty-degree sectors
  localparam int HUE_BITS = 9;
  localparam int DEG_PER_SECTOR = 60;
  localparam int MAX_SECTOR = ((1 << HUE_BITS) - 1) / DEG_PER_SECTOR;
  localparam int SEC_BITS = $clog2(MAX_SECTOR + 1);
  localparam int REM_BITS = $clog2(DEG_PER_SECTOR);

  // Stream word widths, padded to whole bytes
  localparam int IN_BITS = HUE_BITS + 2 * COMP_BITS;
  localparam int IN_DATA_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3 * COMP_BITS;
  localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [COMP_BITS-1:0] comp_t;
  typedef logic [PROD_BITS-1:0] prod_t;
  typedef logic [HUE_BITS-1:0] hue_t;
  typedef logic [SEC_BITS-1:0] sector_t;
  typedef logic [REM_BITS-1:0] rem_t;

  // Sector codes; every other code takes the magenta-to-red placement
  localparam sector_t SEC_RED_TO_YELLOW = SEC_BITS'(0);
  localparam sector_t SEC_YELLOW_TO_GREEN = SEC_BITS'(1);
  localparam sector_t SEC_GREEN_TO_CYAN = SEC_BITS'(2);
  localparam sector_t SEC_CYAN_TO_BLUE = SEC_BITS'(3);
  localparam sector_t SEC_BLUE_TO_MAGENTA = SEC_BITS'(4);

  // Hue split handed from the sector unit to the pipeline
  typedef struct packed {
    sector_t sector;
    rem_t    rem;
  } hue_split_t;

  // Fraction within a sector: floor(rem * COMP_MAX / 60), built at elaboration
  typedef logic [DEG_PER_SECTOR-1:0][COMP_BITS-1:0] frac_table_t;

  function automatic frac_table_t build_frac_table();
    frac_table_t tbl;
    for (int i = 0; i < DEG_PER_SECTOR; i++) begin
      tbl[i] = COMP_BITS'((i * COMP_MAX) / DEG_PER_SECTOR);
    end
    return tbl;
  endfunction

  localparam frac_table_t FRAC_TABLE = build_frac_table();

  // floor(x / COMP_MAX) for x <= COMP_MAX * COMP_MAX, by shift and add
  function automatic comp_t div_by_max(input prod_t x);
    logic [PROD_BITS:0] y;
    logic [PROD_BITS:0] z;
    y = {1'b0, x} + (PROD_BITS + 1)'(1);
    z = y + (y >> COMP_BITS);
    return COMP_BITS'(z >> COMP_BITS);
  endfunction

endpackage

// File: src/hsvr_sector.sv
module hsvr_sector (
  input  hsvr_pkg::hue_t       hue,
  output hsvr_pkg::hue_split_t split
);
  import hsvr_pkg::*;

  sector_t sec;
  hue_t    base;

  // Find the sector by comparing against each sector boundary
  always_comb begin
    sec = SEC_BITS'(0);
    for (int k = 1; k <= MAX_SECTOR; k++) begin
      if (hue >= HUE_BITS'(k * DEG_PER_SECTOR)) begin
        sec = SEC_BITS'(k);
      end
    end
  end

  // Subtract the sector start to get degrees into the sector
  assign base = HUE_BITS'(sec) * HUE_BITS'(DEG_PER_SECTOR);
  assign split.sector = sec;
  assign split.rem = REM_BITS'(hue - base);

endmodule

// File: src/hsv_to_rgb_converter_top.sv
// Channel  | Handshake                  | Word contents (lowest bits first)
// s_axis   | s_tvalid / s_tready        | hue_deg[8:0], saturation[16:9], brightness[24:17]
// m_axis   | m_tvalid / m_tready        | red[7:0], green[15:8], blue[23:16]
//
// Six register stages; a pixel taken into stage 1 moves through stages 2 to 6 to reach m_tdata.
// One pixel per clock sustained while m_tready stays high; depth is set by the two multiply rounds
// (v*(1-s*f)) each followed by a divide-by-all-ones stage.
// Reset clears all stage valid bits; payload registers are not reset.
// Stalls collapse bubbles: a stage loads whenever it is empty or the next
// stage advances, so input is taken while a finished word waits.
module hsv_to_rgb_converter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // hue_deg[8:0], saturation[16:9], brightness[24:17], zero pad above
  input  logic [hsvr_pkg::IN_DATA_BITS-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [hsvr_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
  import hsvr_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;

  hue_t       hue_in;
  comp_t      sat_in;
  comp_t      bri_in;
  hue_split_t split;

  // Stage 1: sector split
  sector_t sec1;
  rem_t    rem1;
  comp_t   s1, v1;
  logic    gray1;
  // Stage 2: fraction and v*(1-s)
  sector_t sec2;
  comp_t   f2, s2, v2;
  prod_t   pp2;
  logic    gray2;
  // Stage 3: s*f and s*(1-f), p
  sector_t sec3;
  prod_t   sf3, sft3;
  comp_t   p3, v3;
  logic    gray3;
  // Stage 4: multiplier arguments of q and t
  sector_t sec4;
  comp_t   qa4, ta4, p4, v4;
  logic    gray4;
  // Stage 5: products of q and t
  sector_t sec5;
  prod_t   qp5, tp5;
  comp_t   p5, v5;
  logic    gray5;
  // Stage 6: output word
  comp_t   red, green, blue;
  comp_t   q6, t6;
  comp_t   red_next, green_next, blue_next;

  assign hue_in = s_tdata[HUE_BITS-1:0];
  assign sat_in = s_tdata[HUE_BITS +: COMP_BITS];
  assign bri_in = s_tdata[HUE_BITS + COMP_BITS +: COMP_BITS];

  hsvr_sector u_sector (
    .hue   (hue_in),
    .split (split)
  );

  // A stage may load when it is empty or its word moves on
  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: capture split hue and components
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sec1  <= split.sector;
      rem1  <= split.rem;
      s1    <= sat_in;
      v1    <= bri_in;
      gray1 <= (sat_in == '0);
    end
  end

  // Stage 2: look up fraction, multiply v by (1-s)
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sec2  <= sec1;
      f2    <= FRAC_TABLE[rem1];
      pp2   <= PROD_BITS'(v1) * PROD_BITS'(comp_t'(COMP_MAX) - s1);
      s2    <= s1;
      v2    <= v1;
      gray2 <= gray1;
    end
  end

  // Stage 3: scale saturation by f and by (1-f), finish p
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sec3  <= sec2;
      sf3   <= PROD_BITS'(s2) * PROD_BITS'(f2);
      sft3  <= PROD_BITS'(s2) * PROD_BITS'(comp_t'(COMP_MAX) - f2);
      p3    <= div_by_max(pp2);
      v3    <= v2;
      gray3 <= gray2;
    end
  end

  // Stage 4: form (1-s*f) and (1-s*(1-f))
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sec4  <= sec3;
      qa4   <= comp_t'(COMP_MAX) - div_by_max(sf3);
      ta4   <= comp_t'(COMP_MAX) - div_by_max(sft3);
      p4    <= p3;
      v4    <= v3;
      gray4 <= gray3;
    end
  end

  // Stage 5: multiply by v
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sec5  <= sec4;
      qp5   <= PROD_BITS'(v4) * PROD_BITS'(qa4);
      tp5   <= PROD_BITS'(v4) * PROD_BITS'(ta4);
      p5    <= p4;
      v5    <= v4;
      gray5 <= gray4;
    end
  end

  // Stage 6: finish q and t, place components by sector
  assign q6 = div_by_max(qp5);
  assign t6 = div_by_max(tp5);

  always_comb begin
    if (gray5) begin
      red_next   = v5;
      green_next = v5;
      blue_next  = v5;
    end else begin
      case (sec5)
        SEC_RED_TO_YELLOW: begin
          red_next = v5; green_next = t6; blue_next = p5;
        end
        SEC_YELLOW_TO_GREEN: begin
          red_next = q6; green_next = v5; blue_next = p5;
        end
        SEC_GREEN_TO_CYAN: begin
          red_next = p5; green_next = v5; blue_next = t6;
        end
        SEC_CYAN_TO_BLUE: begin
          red_next = p5; green_next = q6; blue_next = v5;
        end
        SEC_BLUE_TO_MAGENTA: begin
          red_next = t6; green_next = p5; blue_next = v5;
        end
        default: begin
          red_next = v5; green_next = p5; blue_next = q6;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign m_tvalid = vld[STAGES-1];
  assign m_tdata = OUT_DATA_BITS'({blue, green, red});

  // With the output stage empty, the whole pipe can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  // Words in flight change only by accepted and delivered words
  a_word_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) == $countones($past(vld))
              + int'($past(s_tvalid && s_tready))
              - int'($past(m_tvalid && m_tready))))
    else $error("pipeline lost or repeated a word");

  // Zero saturation gives equal components
  a_gray_out: assert property (@(posedge clk) disable iff (rst)
    (rdy[5] && vld[4] && gray5) |=> (red == green && green == blue))
    else $error("gray pixel has unequal components");

endmodule
